@@ hw/rtl/tbt_pkg.sv @@
// shared types, constants and codes of the thermistor beta temperature block
// no dependencies
package tbt_pkg;

	localparam int OVERSAMPLE_DEF = 16;
	localparam int RAW_BITS_DEF   = 12;

	localparam int SAMPLE_W = 12;
	localparam int TEMP_W   = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam int RES_W  = 20;
	localparam int T0_W   = 15;
	localparam int BETA_W = 14;

	// ln2 in q28
	localparam logic [27:0] LN2_Q28 = 28'd186065279;
	localparam int KELVIN_OFF_CENTI = 27315;
	localparam int TEMP_MAX = 50000;
	localparam int TEMP_PINNED = -99900;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SERIES  = 3'd0,
		REG_NOMINAL = 3'd1,
		REG_T0      = 3'd2,
		REG_BETA    = 3'd3
	} tbt_reg_t;

	typedef struct packed {
		logic [RES_W-1:0]         series;
		logic [RES_W-1:0]         nominal;
		logic signed [T0_W-1:0]   t0;
		logic [BETA_W-1:0]        beta;
	} tbt_cfg_t;

	typedef enum logic [3:0] {
		B_IDLE, B_LOAD, B_NORM, B_SQ, B_ACC, B_LN_LO, B_LN_HI, B_LN_RND,
		B_MUL, B_DEN, B_CHK, B_DIV, B_FIN, B_OUT
	} tbt_bstate_t;

endpackage

@@ hw/rtl/tbt_if.sv @@
// channel interfaces: sample input, result output, configuration write
// depends on tbt_pkg
interface tbt_in_if;
	logic valid;
	logic ready;
	logic [tbt_pkg::SAMPLE_W-1:0] adc_sample;
	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface tbt_out_if;
	logic valid;
	logic ready;
	logic signed [tbt_pkg::TEMP_W-1:0] temp_centi_c;
	logic pinned;
	modport source (output valid, output temp_centi_c, output pinned, input ready);
	modport sink (input valid, input temp_centi_c, input pinned, output ready);
endinterface

interface tbt_cfg_if;
	logic valid;
	logic ready;
	logic [tbt_pkg::CFG_IDX_W-1:0]  index;
	logic [tbt_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/tbt_front.sv @@
// front part: accumulates samples into batches and classifies each batch
// depends on tbt_pkg and tbt_if
module tbt_front #(
	parameter int OVERSAMPLE = 16,
	parameter int RAW_BITS = 12,
	localparam int SUM_W = RAW_BITS + $clog2(OVERSAMPLE)
) (
	input  logic             clk,
	input  logic             arst_n,
	tbt_in_if.sink           samples,
	input  logic             q_full,
	output logic             push,
	output logic [SUM_W-1:0] push_sum,
	output logic             push_pinned
);
	import tbt_pkg::*;

	localparam int CNT_W = $clog2(OVERSAMPLE + 1);
	localparam int FULL = (1 << RAW_BITS) - 1;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      s16;
	logic             last;
	logic             take;

	assign s16  = {{(16 - SAMPLE_W){1'b0}}, samples.adc_sample};
	assign last = (cnt_q == CNT_W'(OVERSAMPLE - 1));
	assign samples.ready = !(last && q_full);
	assign take = samples.valid && samples.ready;

	assign push_sum = sum_q + SUM_W'(s16[RAW_BITS-1:0]);
	assign push = take && last;
	// mean at or below one count, or at or above full scale minus one
	assign push_pinned = (push_sum <= SUM_W'(OVERSAMPLE)) ||
		(push_sum >= SUM_W'((FULL - 1) * OVERSAMPLE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (last) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= push_sum;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/tbt_queue.sv @@
// two-entry queue between the front and back parts
// depends on nothing
module tbt_queue #(
	parameter int W = 17
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         nonempty
);
	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign full = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ hw/rtl/tbt_back.sv @@
// back part: log2 by squaring, ln scaling, beta equation and bit-serial divide
// depends on tbt_pkg and tbt_if
module tbt_back #(
	parameter int OVERSAMPLE = 16,
	parameter int RAW_BITS = 12,
	localparam int SUM_W = RAW_BITS + $clog2(OVERSAMPLE)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tbt_pkg::tbt_cfg_t  cfg_regs,
	input  logic               q_valid,
	input  logic [SUM_W-1:0]   q_sum,
	input  logic               q_pinned,
	output logic               q_pop,
	tbt_out_if.source          results
);
	import tbt_pkg::*;

	localparam int FULL_N = ((1 << RAW_BITS) - 1) * OVERSAMPLE;

	tbt_bstate_t state_q, state_d;

	logic [SUM_W-1:0]        sum_q;
	logic [1:0]              op_q;
	logic [31:0]             a_q;
	logic [4:0]              k_q;
	logic [30:0]             m_q;
	logic [27:0]             r_q;
	logic [4:0]              i_q;
	logic signed [35:0]      l_q;
	logic [44:0]             plo_q;
	logic [44:0]             phi_q;
	logic signed [31:0]      lnq_q;
	logic signed [48:0]      tl_q;
	logic [20:0]             bb_q;
	logic signed [49:0]      den_q;
	logic [36:0]             nb_q;
	logic [61:0]             dvd_q;
	logic [48:0]             rem_q;
	logic [5:0]              cnt_q;
	logic signed [TEMP_W-1:0] res_q;
	logic                    res_pin_q;
	logic                    out_valid_q;
	logic signed [TEMP_W-1:0] out_temp_q;
	logic                    out_pin_q;

	logic [SUM_W-1:0]  num;
	logic [31:0]       operand;
	logic [61:0]       sq;
	logic [32:0]       logv;
	logic [35:0]       mag;
	logic [62:0]       ln_tot;
	logic [30:0]       ln_mag;
	logic [15:0]       t0c;
	logic signed [16:0] t0c_s;
	logic [49:0]       trial;
	logic              out_free;

	assign num = SUM_W'(FULL_N) - sum_q;
	assign t0c_s = 17'(cfg_regs.t0) + 17'sd27315;
	assign t0c = t0c_s[15:0];
	assign sq = 62'(m_q) * 62'(m_q);
	assign logv = {k_q, r_q};
	assign mag = l_q[35] ? 36'(-l_q) : 36'(l_q);
	assign ln_tot = 63'({phi_q, 17'b0}) + 63'(plo_q) + 63'(64'h8000_0000);
	assign ln_mag = ln_tot[62:32];
	assign trial = {rem_q, dvd_q[61]} - {1'b0, den_q[48:0]};
	assign out_free = !out_valid_q || results.ready;

	always_comb begin
		unique case (op_q)
			2'd0: operand = 32'(cfg_regs.series);
			2'd1: operand = 32'(num);
			2'd2: operand = 32'(sum_q);
			default: operand = 32'(cfg_regs.nominal);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_pinned || cfg_regs.series == '0 || cfg_regs.nominal == '0)
						state_d = B_OUT;
					else
						state_d = B_LOAD;
				end
			end
			B_LOAD: state_d = B_NORM;
			B_NORM: if (a_q[31]) state_d = B_SQ;
			B_SQ: if (i_q == 5'd0) state_d = B_ACC;
			B_ACC: state_d = (op_q == 2'd3) ? B_LN_LO : B_LOAD;
			B_LN_LO: state_d = B_LN_HI;
			B_LN_HI: state_d = B_LN_RND;
			B_LN_RND: state_d = B_MUL;
			B_MUL: state_d = B_DEN;
			B_DEN: state_d = B_CHK;
			B_CHK: state_d = (den_q[49] || den_q == '0) ? B_OUT : B_DIV;
			B_DIV: if (cnt_q == 6'd0) state_d = B_FIN;
			B_FIN: state_d = B_OUT;
			B_OUT: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				sum_q <= q_sum;
				op_q <= 2'd0;
				l_q <= '0;
				res_pin_q <= q_pinned;
				res_q <= q_pinned ? TEMP_W'(TEMP_PINNED) : TEMP_W'(-KELVIN_OFF_CENTI);
			end
			B_LOAD: begin
				a_q <= operand;
				k_q <= 5'd31;
			end
			B_NORM: begin
				if (a_q[31]) begin
					m_q <= a_q[31:1];
					r_q <= '0;
					i_q <= 5'd27;
				end else begin
					a_q <= {a_q[30:0], 1'b0};
					k_q <= k_q - 1'b1;
				end
			end
			B_SQ: begin
				if (sq[61]) begin
					m_q <= sq[61:31];
					r_q[i_q] <= 1'b1;
				end else begin
					m_q <= sq[60:30];
				end
				i_q <= i_q - 1'b1;
			end
			B_ACC: begin
				if (op_q[1]) l_q <= l_q - 36'(logv);
				else l_q <= l_q + 36'(logv);
				op_q <= op_q + 1'b1;
			end
			B_LN_LO: plo_q <= 45'(mag[16:0]) * 45'(LN2_Q28);
			B_LN_HI: phi_q <= 45'(mag[33:17]) * 45'(LN2_Q28);
			B_LN_RND: lnq_q <= l_q[35] ? -32'(ln_mag) : 32'(ln_mag);
			B_MUL: begin
				tl_q <= 49'($signed({1'b0, t0c})) * 49'(lnq_q);
				bb_q <= 21'(cfg_regs.beta) * 21'd100;
			end
			B_DEN: begin
				den_q <= $signed({5'b0, bb_q, 24'b0}) + 50'(tl_q);
				nb_q <= 37'(bb_q) * 37'(t0c);
			end
			B_CHK: begin
				dvd_q <= 62'({nb_q, 24'b0}) + 62'(den_q[48:1]);
				rem_q <= '0;
				cnt_q <= 6'd61;
				res_pin_q <= 1'b0;
				res_q <= TEMP_W'(TEMP_MAX);
			end
			B_DIV: begin
				if (!trial[49]) begin
					rem_q <= trial[48:0];
					dvd_q <= {dvd_q[60:0], 1'b1};
				end else begin
					rem_q <= {rem_q[47:0], dvd_q[61]};
					dvd_q <= {dvd_q[60:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
			end
			B_FIN: begin
				if (dvd_q > 62'(TEMP_MAX + KELVIN_OFF_CENTI))
					res_q <= TEMP_W'(TEMP_MAX);
				else
					res_q <= TEMP_W'(dvd_q[17:0] - 18'(KELVIN_OFF_CENTI));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == B_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_OUT && out_free) begin
			out_temp_q <= res_q;
			out_pin_q <= res_pin_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.temp_centi_c = out_temp_q;
	assign results.pinned = out_pin_q;

endmodule

@@ hw/rtl/thermistor_beta_temperature.sv @@
// top level of the thermistor beta temperature converter
// depends on tbt_pkg, tbt_if, tbt_front, tbt_queue and tbt_back
//
// Takes one raw adc item per cycle on samples and sums OVERSAMPLE of them into a
// batch; each finished batch produces one result item on results. A batch whose
// mean is within one count of either rail gives pinned = 1 and -999.00 C; any
// other batch is converted with the Beta equation to hundredths of a degree C,
// saturated at 500.00 C. A finished batch sits in a two-entry queue while the
// back part converts it, so samples are stalled only when the queue is full on
// the last item of a batch. A conversion pops the batch, runs four log2 passes
// (load, normalizing shift, squaring steps on a 31x31 multiplier for 28 fraction
// bits, accumulate), the ln scaling and the beta terms, a one-bit-per-cycle
// divider for a 62-bit quotient and a clamp, and hands the result off once the
// output is free. Pinned batches and zero resistances go from the pop straight
// to the handoff, and a non-positive denominator skips the divider and the clamp.
// Configuration writes are taken every cycle and must be made while no batch is
// in flight.
module thermistor_beta_temperature #(
	parameter int OVERSAMPLE = tbt_pkg::OVERSAMPLE_DEF,
	parameter int RAW_BITS = tbt_pkg::RAW_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	tbt_in_if.sink   samples,
	tbt_out_if.source results,
	tbt_cfg_if.sink  cfg
);
	import tbt_pkg::*;

	localparam int SUM_W = RAW_BITS + $clog2(OVERSAMPLE);

	tbt_cfg_t         cfg_q;
	logic             push;
	logic [SUM_W-1:0] push_sum;
	logic             push_pinned;
	logic             q_full;
	logic             q_nonempty;
	logic             q_pop;
	logic [SUM_W:0]   q_rdata;

	// configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.series <= RES_W'(10000);
			cfg_q.nominal <= RES_W'(10000);
			cfg_q.t0 <= T0_W'(2500);
			cfg_q.beta <= BETA_W'(3950);
		end else if (cfg.valid) begin
			// indexes past the list are ignored
			unique case (cfg.index)
				REG_SERIES:  cfg_q.series <= cfg.data[RES_W-1:0];
				REG_NOMINAL: cfg_q.nominal <= cfg.data[RES_W-1:0];
				REG_T0:      cfg_q.t0 <= cfg.data[T0_W-1:0];
				REG_BETA:    cfg_q.beta <= cfg.data[BETA_W-1:0];
				default: ;
			endcase
		end
	end

	// batch accumulation and rail check
	tbt_front #(.OVERSAMPLE(OVERSAMPLE), .RAW_BITS(RAW_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.q_full(q_full),
		.push(push),
		.push_sum(push_sum),
		.push_pinned(push_pinned)
	);

	// finished batches wait here for the converter
	tbt_queue #(.W(SUM_W + 1)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata({push_pinned, push_sum}),
		.pop(q_pop),
		.rdata(q_rdata),
		.full(q_full),
		.nonempty(q_nonempty)
	);

	// log, beta equation and divide, one batch at a time
	tbt_back #(.OVERSAMPLE(OVERSAMPLE), .RAW_BITS(RAW_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_regs(cfg_q),
		.q_valid(q_nonempty),
		.q_sum(q_rdata[SUM_W-1:0]),
		.q_pinned(q_rdata[SUM_W]),
		.q_pop(q_pop),
		.results(results)
	);

endmodule

@@ tb/tb_thermistor_beta_temperature_if.sv @@
// this file was left empty on purpose: the channel interfaces come with the rtl
// (tbt_if.sv), and the bench instantiates tbt_in_if, tbt_out_if and tbt_cfg_if from there
`timescale 1ns / 1ps

@@ tb/tb_thermistor_beta_temperature.sv @@
// self-checking bench for thermistor_beta_temperature: batches of adc samples in,
// one temperature result per batch out, checked against a local bit-exact predictor
// depends on tbt_pkg, tbt_if and the rtl of the block
`timescale 1ns / 1ps

module tb_thermistor_beta_temperature;
	import tbt_pkg::*;

	localparam int OVS = OVERSAMPLE_DEF;
	localparam longint FULL = (64'd1 << RAW_BITS_DEF) - 1;

	logic clk;
	logic arst_n;
	int errors = 0;

	tbt_in_if samples();
	tbt_out_if results();
	tbt_cfg_if cfg();

	thermistor_beta_temperature dut (
		.clk(clk), .arst_n(arst_n), .samples(samples), .results(results), .cfg(cfg)
	);

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic pinned;
	} temp_res_t;

	// one line and a count per mismatch
	task automatic report(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	class temp_board;
		temp_res_t pending[$];
		logic [RES_W-1:0] series, nominal;
		logic signed [T0_W-1:0] t0;
		logic [BETA_W-1:0] beta;
		longint batch_sum;
		int batch_cnt;

		function void restart();
			series = RES_W'(10000); nominal = RES_W'(10000);
			t0 = T0_W'(2500); beta = BETA_W'(3950);
			batch_sum = 0; batch_cnt = 0;
		endfunction

		function void write_reg(tbt_reg_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_SERIES: series = v[RES_W-1:0];
				REG_NOMINAL: nominal = v[RES_W-1:0];
				REG_T0: t0 = v[T0_W-1:0];
				REG_BETA: beta = v[BETA_W-1:0];
				default: ;
			endcase
		endfunction

		// log2 in q28 by repeated squaring of the q30 mantissa
		function longint log2q(longint a);
			longint unsigned m, r;
			int k;
			k = 63;
			while (k > 0 && a[k] == 0) k--;
			m = (k >= 30) ? (a >> (k - 30)) : (a << (30 - k));
			r = longint'(k) << 28;
			for (int i = 27; i >= 0; i--) begin
				m = (m * m) >> 30;
				if (m >= (64'd1 << 31)) begin
					m >>= 1;
					r[i] = 1'b1;
				end
			end
			return r;
		endfunction

		function int beta_temp(longint s);
			longint l, lnq, t0c, d, b;
			longint unsigned mag, n, t;
			if (series == 0 || nominal == 0) return -KELVIN_OFF_CENTI;
			l = log2q(longint'(series)) + log2q(FULL * OVS - s) - log2q(s)
				- log2q(longint'(nominal));
			mag = (l < 0) ? -l : l;
			mag = (mag * longint'(LN2_Q28) + (64'd1 << 31)) >> 32;
			lnq = (l < 0) ? -longint'(mag) : longint'(mag);
			t0c = longint'(t0) + KELVIN_OFF_CENTI;
			b = longint'(beta);
			d = 100 * b * (64'sd1 <<< 24) + t0c * lnq;
			if (d <= 0) return TEMP_MAX;
			n = longint'(100 * b * t0c) << 24;
			t = (n + longint'(d) / 2) / longint'(d);
			if (t > TEMP_MAX + KELVIN_OFF_CENTI) return TEMP_MAX;
			return int'(t) - KELVIN_OFF_CENTI;
		endfunction

		// note an accepted sample item
		function void note_sample(logic [SAMPLE_W-1:0] v);
			temp_res_t r;
			batch_sum += v & FULL;
			batch_cnt++;
			if (batch_cnt < OVS) return;
			if (batch_sum <= OVS || batch_sum >= (FULL - 1) * OVS) begin
				r.temp = TEMP_W'(TEMP_PINNED); r.pinned = 1'b1;
			end else begin
				r.temp = TEMP_W'(beta_temp(batch_sum)); r.pinned = 1'b0;
			end
			pending.push_back(r);
			batch_sum = 0; batch_cnt = 0;
		endfunction

		task check(logic signed [TEMP_W-1:0] tp, logic pn);
			temp_res_t e;
			if (pending.size() == 0) begin
				report("result item with nothing pending");
				return;
			end
			e = pending.pop_front();
			if (tp !== e.temp)
				report($sformatf("temp got %0d want %0d", tp, e.temp));
			if (pn !== e.pinned)
				report($sformatf("pinned got %b want %b", pn, e.pinned));
		endtask
	endclass

	temp_board board = new();
	bit calm = 0;
	bit src_idle_on = 1;
	int hold_off = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb_thermistor_beta_temperature failed");
		$finish;
	end

	// receiver: random stalls in bursts, plus one long hold-off
	initial begin
		int n;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				results.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 15);
				results.ready <= 1'b0;
				repeat (n) @(posedge clk);
				results.ready <= 1'b1;
			end else results.ready <= 1'b1;
		end
	end

	// check every accepted result item
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready)
			board.check(results.temp_centi_c, results.pinned);
	end

	// offer one sample item, with random idle bursts before it
	task automatic send_sample(logic [SAMPLE_W-1:0] v);
		if (src_idle_on && !calm && $urandom_range(0, 7) == 0) begin
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.adc_sample <= v;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		board.note_sample(v);
	endtask

	task automatic drain();
		samples.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_cfg(tbt_reg_t idx, logic [CFG_DATA_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		board.write_reg(idx, v);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// a batch with a chosen mean plus small random spread
	task automatic send_batch(int mean, int spread);
		int v;
		for (int i = 0; i < OVS; i++) begin
			v = mean + $urandom_range(0, 2 * spread) - spread;
			if (v < 0) v = 0;
			if (v > 4095) v = 4095;
			send_sample(SAMPLE_W'(v));
		end
	endtask

	task automatic random_cfg(bit extreme);
		if (extreme) begin
			write_cfg(REG_SERIES, $urandom_range(0, 1) ? 20'hFFFFF : 20'd1);
			write_cfg(REG_NOMINAL, $urandom_range(0, 1) ? 20'hFFFFF : 20'd1);
			write_cfg(REG_T0, $urandom_range(0, 1) ? 20'(-5500) : 20'd15000);
			write_cfg(REG_BETA, $urandom_range(0, 1) ? 20'd10000 : 20'd1000);
		end else begin
			write_cfg(REG_SERIES, CFG_DATA_W'($urandom_range(1000, 200000)));
			write_cfg(REG_NOMINAL, CFG_DATA_W'($urandom_range(1000, 200000)));
			write_cfg(REG_T0, 20'($signed($urandom_range(0, 20500)) - 5500));
			write_cfg(REG_BETA, CFG_DATA_W'($urandom_range(1000, 10000)));
		end
	endtask

	initial begin
		samples.valid = 1'b0;
		samples.adc_sample = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_SERIES;
		cfg.data = '0;
		board.restart();
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: rails, just inside the rails, mid scale, every bit
		send_batch(0, 0);
		send_batch(4095, 0);
		for (int i = 0; i < OVS; i++) send_sample(i == 0 ? 12'd17 : 12'd1);
		for (int i = 0; i < OVS; i++) send_sample(i == 0 ? 12'd4093 : 12'd4094);
		for (int i = 0; i < OVS; i++) send_sample(i[0] ? 12'hAAA : 12'h555);
		drain();

		// zero resistances, zero beta, odd raw values outside the documented range
		write_cfg(REG_SERIES, '0);
		send_batch(2048, 3);
		drain();
		write_cfg(REG_SERIES, 20'hFFFFF);
		write_cfg(REG_NOMINAL, '0);
		send_batch(1000, 3);
		drain();
		write_cfg(REG_NOMINAL, 20'd1);
		write_cfg(REG_BETA, '0);
		write_cfg(REG_T0, 20'h7FFF);
		send_batch(3000, 3);
		drain();
		write_cfg(REG_BETA, 20'h3FFF);
		write_cfg(REG_T0, 20'h4000);
		send_batch(50, 3);
		drain();

		// random phases, several settings including the extremes
		for (int ph = 0; ph < 9; ph++) begin
			random_cfg(ph % 3 == 0);
			if (ph == 4) hold_off = 2500;
			if (ph == 8) calm = 1;
			for (int b = 0; b < 8; b++) begin
				case ($urandom_range(0, 9))
					0: send_batch($urandom_range(0, 2) ? 0 : 4095, 1);
					1: for (int i = 0; i < OVS; i++)
						send_sample(SAMPLE_W'($urandom_range(0, 4095)));
					default: send_batch($urandom_range(20, 4075), $urandom_range(0, 40));
				endcase
			end
			// sender pause until every result has come
			drain();
		end
		calm = 1;
		drain();
		if (errors == 0)
			$display("tb_thermistor_beta_temperature passed");
		else
			$display("tb_thermistor_beta_temperature failed");
		$finish;
	end

endmodule
